// File: rtl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    // Fixed widths of the stream fields
    localparam int AXIS_FIELD_W = 10;
    localparam int COORD_W      = 11;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Position on the curve
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REG1,
        PH_REG2,
        PH_DONE
    } phase_t;

    // Controller sequence states
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_SQ_A,
        ST_SQ_B,
        ST_MUL_BA,
        ST_INIT,
        ST_STEP,
        ST_UPD,
        ST_LOOK,
        ST_MUL_XX,
        ST_MUL_BS,
        ST_MUL_YY,
        ST_MUL_AY,
        ST_MUL_AB,
        ST_R2_INIT,
        ST_EMIT
    } ctrl_state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_A,
        OP_SQ_B,
        OP_MUL_BA,
        OP_INIT,
        OP_STEP,
        OP_UPD,
        OP_FINISH,
        OP_MUL_XX,
        OP_MUL_BS,
        OP_MUL_YY,
        OP_MUL_AY,
        OP_MUL_AB,
        OP_R2_INIT,
        OP_EMIT
    } dp_op_t;

    // Command from controller to datapath
    typedef struct packed {
        dp_op_t     op;
        logic [1:0] emit_idx;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        phase_t phase;
        logic   r1_exit;
        logic   r2_end;
        logic   out_free;
    } dp_status_t;

endpackage

// File: rtl/mer_ctrl.sv
// Sequencing state machine of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_command,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_cmd_t    cmd
);
    import mer_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [1:0]  emit_cnt_reg;
    logic [1:0]  emit_cnt_next;

    // State and emit counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_WAIT;
            emit_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        emit_cnt_next = emit_cnt_reg;
        case (state_reg)
            ST_WAIT:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_START)
                    begin
                        state_next = ST_SQ_A;
                    end
                    else if (status.phase == PH_REG1 || status.phase == PH_REG2)
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_SQ_A:    state_next = ST_SQ_B;
            ST_SQ_B:    state_next = ST_MUL_BA;
            ST_MUL_BA:  state_next = ST_INIT;
            ST_INIT:    state_next = ST_LOOK;
            ST_STEP:    state_next = ST_UPD;
            ST_UPD:     state_next = ST_LOOK;
            ST_LOOK:
            begin
                if (status.r1_exit)
                begin
                    state_next = ST_MUL_XX;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL_XX:  state_next = ST_MUL_BS;
            ST_MUL_BS:  state_next = ST_MUL_YY;
            ST_MUL_YY:  state_next = ST_MUL_AY;
            ST_MUL_AY:  state_next = ST_MUL_AB;
            ST_MUL_AB:  state_next = ST_R2_INIT;
            ST_R2_INIT: state_next = ST_LOOK;
            ST_EMIT:
            begin
                // One mirrored point leaves each time the output slot is free
                if (status.out_free)
                begin
                    emit_cnt_next = emit_cnt_reg + 2'd1;
                    if (emit_cnt_reg == 2'd3)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            default:    state_next = ST_WAIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_WAIT);
        cmd.op       = OP_NONE;
        cmd.emit_idx = emit_cnt_reg;
        case (state_reg)
            ST_WAIT:
            begin
                if (in_valid && in_command == CMD_START)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_SQ_A:    cmd.op = OP_SQ_A;
            ST_SQ_B:    cmd.op = OP_SQ_B;
            ST_MUL_BA:  cmd.op = OP_MUL_BA;
            ST_INIT:    cmd.op = OP_INIT;
            ST_STEP:    cmd.op = OP_STEP;
            ST_UPD:     cmd.op = OP_UPD;
            ST_LOOK:
            begin
                if (!status.r1_exit && status.r2_end)
                begin
                    cmd.op = OP_FINISH;
                end
            end
            ST_MUL_XX:  cmd.op = OP_MUL_XX;
            ST_MUL_BS:  cmd.op = OP_MUL_BS;
            ST_MUL_YY:  cmd.op = OP_MUL_YY;
            ST_MUL_AY:  cmd.op = OP_MUL_AY;
            ST_MUL_AB:  cmd.op = OP_MUL_AB;
            ST_R2_INIT: cmd.op = OP_R2_INIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: rtl/mer_datapath.sv
// Datapath of the midpoint ellipse rasterizer: decision terms, shared multiplier, output register.
`timescale 1ns / 1ps

module mer_datapath #(
    parameter int AXIS_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mer_pkg::AXIS_FIELD_W-1:0]    semi_axis_x,
    input  logic [mer_pkg::AXIS_FIELD_W-1:0]    semi_axis_y,
    input  mer_pkg::dp_cmd_t                    cmd,
    output mer_pkg::dp_status_t                 status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [mer_pkg::COORD_W-1:0]  point_x,
    output logic signed [mer_pkg::COORD_W-1:0]  point_y,
    output logic                                last_of_step,
    output logic                                curve_done
);
    import mer_pkg::*;

    localparam int N     = AXIS_BITS;
    localparam int SQ_W  = 2 * N;
    localparam int MW    = 2 * N;
    localparam int PW    = 4 * N;
    localparam int ACC_W = 4 * N + 1;
    localparam int DW    = 4 * N + 4;
    localparam int EW    = DW + 3;

    // Control registers
    phase_t phase_reg;
    phase_t phase_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Algorithm registers
    logic [N-1:0]          a_reg, a_next;
    logic [N-1:0]          b_reg, b_next;
    logic [N-1:0]          x_reg, x_next;
    logic [N-1:0]          y_reg, y_next;
    logic [SQ_W-1:0]       a_sq_reg, a_sq_next;
    logic [SQ_W-1:0]       b_sq_reg, b_sq_next;
    logic signed [DW-1:0]  d_reg, d_next;
    logic signed [DW-1:0]  dx_reg, dx_next;
    logic signed [DW-1:0]  dy_reg, dy_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  flag_reg, flag_next;

    // Output registers
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic                      last_reg, last_next;
    logic                      done_reg, done_next;

    // Combinational helpers
    logic [MW-1:0]         mul_l;
    logic [MW-1:0]         mul_r;
    logic [PW-1:0]         mul_p;
    logic [N-1:0]          y_m1;
    logic signed [DW-1:0]  a_sq_w;
    logic signed [DW-1:0]  b_sq_w;
    logic signed [DW-1:0]  prod_w;
    logic signed [EW-1:0]  r2_t;
    logic signed [EW-1:0]  r2_v;
    logic signed [EW-1:0]  r2_mag;
    logic signed [EW-1:0]  r2_q;
    logic [COORD_W-1:0]    x_c;
    logic [COORD_W-1:0]    y_c;

    assign a_sq_w = DW'(a_sq_reg);
    assign b_sq_w = DW'(b_sq_reg);
    assign prod_w = DW'(prod_reg);
    assign x_c    = COORD_W'(x_reg);
    assign y_c    = COORD_W'(y_reg);

    // Magnitude of y-1; its square equals (y-1)^2 also when y is zero
    assign y_m1 = (y_reg == '0) ? N'(1) : y_reg - N'(1);

    // Region-2 start value, divided by four with truncation toward zero
    assign r2_t   = $signed(EW'(acc_reg)) - $signed(EW'(prod_reg));
    assign r2_v   = (r2_t <<< 2) + $signed(EW'(b_sq_reg));
    assign r2_mag = r2_v[EW-1] ? -r2_v : r2_v;
    assign r2_q   = r2_v[EW-1] ? -(r2_mag >>> 2) : (r2_mag >>> 2);

    // Shared multiplier operand selection
    always_comb
    begin
        mul_l = '0;
        mul_r = '0;
        case (cmd.op)
            OP_SQ_A:
            begin
                mul_l = MW'(a_reg);
                mul_r = MW'(a_reg);
            end
            OP_SQ_B:
            begin
                mul_l = MW'(b_reg);
                mul_r = MW'(b_reg);
            end
            OP_MUL_BA:
            begin
                mul_l = MW'(b_reg);
                mul_r = MW'(a_sq_reg);
            end
            OP_MUL_XX:
            begin
                mul_l = MW'(x_reg);
                mul_r = MW'(x_reg);
            end
            OP_MUL_BS:
            begin
                mul_l = MW'(b_sq_reg);
                mul_r = prod_reg[MW-1:0] + MW'(x_reg);
            end
            OP_MUL_YY:
            begin
                mul_l = MW'(y_m1);
                mul_r = MW'(y_m1);
            end
            OP_MUL_AY:
            begin
                mul_l = MW'(a_sq_reg);
                mul_r = prod_reg[MW-1:0];
            end
            OP_MUL_AB:
            begin
                mul_l = MW'(a_sq_reg);
                mul_r = MW'(b_sq_reg);
            end
            default:
            begin
                mul_l = '0;
                mul_r = '0;
            end
        endcase
    end

    assign mul_p = mul_l * mul_r;

    // Next values of all datapath registers
    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        a_sq_next      = a_sq_reg;
        b_sq_next      = b_sq_reg;
        d_next         = d_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        flag_next      = flag_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                a_next     = N'(semi_axis_x);
                b_next     = N'(semi_axis_y);
                x_next     = '0;
                y_next     = N'(semi_axis_y);
                dx_next    = '0;
                phase_next = PH_REG1;
            end
            OP_SQ_A:   a_sq_next = mul_p[SQ_W-1:0];
            OP_SQ_B:   b_sq_next = mul_p[SQ_W-1:0];
            OP_MUL_BA: prod_next = mul_p;
            OP_INIT:
            begin
                d_next  = b_sq_w - prod_w + (a_sq_w >>> 2);
                dy_next = prod_w <<< 1;
            end
            OP_STEP:
            begin
                if (phase_reg == PH_REG1)
                begin
                    // Region 1: x always moves; y moves when the midpoint is outside
                    flag_next = d_reg[DW-1];
                    x_next    = x_reg + N'(1);
                    dx_next   = dx_reg + (b_sq_w <<< 1);
                    if (!d_reg[DW-1])
                    begin
                        if (y_reg != '0)
                        begin
                            y_next = y_reg - N'(1);
                        end
                        dy_next = dy_reg - (a_sq_w <<< 1);
                    end
                end
                else if (phase_reg == PH_REG2)
                begin
                    // Region 2: y always moves; x moves when the midpoint is inside
                    flag_next = !d_reg[DW-1] && (d_reg != '0);
                    y_next    = y_reg - N'(1);
                    dy_next   = dy_reg - (a_sq_w <<< 1);
                    if (d_reg[DW-1] || d_reg == '0)
                    begin
                        x_next  = x_reg + N'(1);
                        dx_next = dx_reg + (b_sq_w <<< 1);
                    end
                end
            end
            OP_UPD:
            begin
                if (phase_reg == PH_REG1)
                begin
                    d_next = d_reg + b_sq_w + dx_reg - (flag_reg ? '0 : dy_reg);
                end
                else if (phase_reg == PH_REG2)
                begin
                    d_next = d_reg + a_sq_w - dy_reg + (flag_reg ? '0 : dx_reg);
                end
            end
            OP_FINISH: phase_next = PH_DONE;
            OP_MUL_XX: prod_next = mul_p;
            OP_MUL_BS: prod_next = mul_p;
            OP_MUL_YY:
            begin
                acc_next  = ACC_W'(prod_reg);
                prod_next = mul_p;
            end
            OP_MUL_AY: prod_next = mul_p;
            OP_MUL_AB:
            begin
                acc_next  = acc_reg + ACC_W'(prod_reg);
                prod_next = mul_p;
            end
            OP_R2_INIT:
            begin
                d_next     = r2_q[DW-1:0];
                phase_next = PH_REG2;
            end
            OP_EMIT:
            begin
                // Mirror order: (x,y), (-x,y), (x,-y), (-x,-y)
                out_valid_next = 1'b1;
                px_next        = cmd.emit_idx[0] ? -x_c : x_c;
                py_next        = cmd.emit_idx[1] ? -y_c : y_c;
                last_next      = (cmd.emit_idx == 2'd3);
                done_next      = (cmd.emit_idx == 2'd3) && (phase_reg == PH_DONE);
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Control registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_sq_reg <= a_sq_next;
        b_sq_reg <= b_sq_next;
        d_reg    <= d_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        flag_reg <= flag_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    // Status towards the controller
    assign status.phase    = phase_reg;
    assign status.r1_exit  = (phase_reg == PH_REG1) && !(dx_reg < dy_reg);
    assign status.r2_end   = (phase_reg == PH_REG2) && (y_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign last_of_step = last_reg;
    assign curve_done   = done_reg;

endmodule

// File: rtl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

// Origin-centred midpoint ellipse generator.
// The input stream carries one item per command: tuser holds the command
// (start or step), tdata holds the semi-axes a and b used by a start.
// A start sets up the decision terms and gives the four mirrored points of
// (0,b); each step advances one point of the first-quadrant arc and gives
// its four mirrors. A step while idle or after the curve is finished is
// taken and gives nothing.
// The output stream carries one point per item: tlast marks the fourth
// point of a step, tuser marks the last point of the whole curve.
// A step moves the point by the decision, updates the decision term, looks
// ahead and then gives its four output points; the step that leaves region 1
// adds five passes through the shared multiplier that set up the region-2
// decision term. A start squares the semi-axes and forms b times a squared in
// three multiplier passes, sets up the decision terms, looks ahead and emits.
// When the receiver stalls, the output register holds its point and the
// sequencer waits; input is taken once the fourth point is in the register.
// Reset returns the block to idle with no output pending.
module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mer_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // semi_axis_x, semi_axis_y, zero pad
    input  logic                            s_axis_tuser,   // command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mer_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // point_x, point_y, zero pad
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser    // curve_done
);
    import mer_pkg::*;

    dp_cmd_t                   cmd;
    dp_status_t                status;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    // Sequencer
    mer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser),
        .status     (status),
        .cmd        (cmd)
    );

    // Arithmetic and output register
    mer_datapath #(
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .semi_axis_x  (s_axis_tdata[AXIS_FIELD_W-1:0]),
        .semi_axis_y  (s_axis_tdata[2*AXIS_FIELD_W-1:AXIS_FIELD_W]),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (m_axis_tlast),
        .curve_done   (m_axis_tuser)
    );

    // Output packing, first field in the lowest bits
    assign m_axis_tdata = {{(M_TDATA_W - 2 * COORD_W){1'b0}}, point_y, point_x};

endmodule

// File: rtl/mer_checker.sv
// Port-level checks of the midpoint ellipse rasterizer and their binding.
`timescale 1ns / 1ps

module mer_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mer_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic                          m_axis_tuser
);
    import mer_pkg::*;

    // No output item is offered on the cycle after a reset edge
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    // A start keeps the block busy on the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_START) |=> !s_axis_tready)
        else $error("input taken directly after a start");

    // The end of a curve always falls on the fourth point of a step
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("curve end without step end");

    // A stalled output item holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
         && $stable(m_axis_tuser)))
        else $error("stalled output item changed");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
